// ----- src/bid_pkg.sv -----
// ----------------------------------------------------------------------------
// Bytecode instruction decoder package
// Shared types, opcode constants and argument size decode.
// ----------------------------------------------------------------------------
package bid_pkg;

   // Opcodes with a fixed argument layout
   localparam logic [4:0] OPC_LONG_ARG = 5'h01;   // one 4-byte argument
   localparam logic [4:0] OPC_SHORT_A  = 5'd9;    // one 2-byte argument
   localparam logic [4:0] OPC_SHORT_B  = 5'd12;
   localparam logic [4:0] OPC_SHORT_C  = 5'd15;
   localparam logic [4:0] OPC_BYTE_ARG = 5'h10;   // coding byte, one 1-byte argument
   localparam logic [4:0] OPC_MAX      = 5'd16;

   // Opcodes whose wide argument code reads as 2 bytes
   localparam logic [4:0] OPC_HALF_A   = 5'h0a;
   localparam logic [4:0] OPC_HALF_B   = 5'h0b;
   localparam logic [4:0] OPC_HALF_C   = 5'h0e;

   // Argument type codes in the coding byte
   localparam logic [1:0] ARG_NONE = 2'b00;
   localparam logic [1:0] ARG_BYTE = 2'b01;
   localparam logic [1:0] ARG_WIDE = 2'b10;
   localparam logic [1:0] ARG_HALF = 2'b11;

   localparam int NUM_ARGS = 4;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_CODING = 3'b010,
      PH_ARGS   = 3'b100
   } phase_type;

   typedef struct packed {
      phase_type                 phase;
      logic [4:0]                opcode;
      logic [7:0]                coding;
      logic [1:0]                slot;
      logic [2:0]                left;
      logic [NUM_ARGS-1:0][31:0] accum;
      logic [4:0]                count;
   } state_type;

   typedef struct packed {
      logic                      valid_opcode;
      logic [4:0]                opcode;
      logic [7:0]                coding_byte;
      logic [NUM_ARGS-1:0][31:0] args;
      logic [4:0]                instr_length;
   } rsp_type;

   typedef struct packed {
      logic       found;
      logic [1:0] slot;
      logic [2:0] size;
   } adv_type;

   // Byte size of one argument slot
   function automatic logic [2:0] field_size(logic [4:0] opc, logic [7:0] coding,
                                             logic [1:0] slot);
      logic [1:0] t;
      logic [2:0] size;
      case (slot)
         2'd0:    t = coding[7:6];
         2'd1:    t = coding[5:4];
         2'd2:    t = coding[3:2];
         default: t = coding[1:0];
      endcase
      if (opc == OPC_BYTE_ARG) begin
         size = (slot == 2'd0) ? 3'd1 : 3'd0;
      end else if (opc == OPC_LONG_ARG) begin
         size = (slot == 2'd0) ? 3'd4 : 3'd0;
      end else if (opc == OPC_SHORT_A || opc == OPC_SHORT_B || opc == OPC_SHORT_C) begin
         size = (slot == 2'd0) ? 3'd2 : 3'd0;
      end else begin
         case (t)
            ARG_BYTE: size = 3'd1;
            ARG_HALF: size = 3'd2;
            ARG_WIDE: size = (opc == OPC_HALF_A || opc == OPC_HALF_B ||
                              opc == OPC_HALF_C) ? 3'd2 : 3'd4;
            default:  size = 3'd0;
         endcase
      end
      return size;
   endfunction

   // First present argument at or after slot 'from'
   function automatic adv_type find_arg(logic [4:0] opc, logic [7:0] coding,
                                        logic [2:0] from);
      adv_type    r;
      logic [2:0] s;
      r = '0;
      for (int i = 0; i < NUM_ARGS; i++) begin
         s = field_size(opc, coding, 2'(i));
         if (!r.found && 3'(i) >= from && s != 3'd0) begin
            r.found = 1'b1;
            r.slot  = 2'(i);
            r.size  = s;
         end
      end
      return r;
   endfunction

endpackage

// ----- src/bid_step.sv -----
// ----------------------------------------------------------------------------
// Decoder step
// Next state and decoded result for one accepted code byte.
// ----------------------------------------------------------------------------
module bid_step
   import bid_pkg::*;
(
   input  state_type  cur_state,
   input  logic [7:0] code_byte,
   input  logic       first_byte,
   output state_type  nxt_state,
   output logic       emit,
   output rsp_type    result
);

   adv_type    adv;
   logic [2:0] left_dec;
   logic       bad_opc;

   always_comb begin
      nxt_state = cur_state;
      emit      = 1'b0;
      adv       = '0;
      left_dec  = 3'd0;
      bad_opc   = (code_byte == 8'd0) || (code_byte > 8'(OPC_MAX));

      if (first_byte) begin
         // Start a new instruction, drop any partial one
         nxt_state.accum  = '0;
         nxt_state.coding = 8'd0;
         nxt_state.slot   = 2'd0;
         nxt_state.left   = 3'd0;
         nxt_state.count  = 5'd1;
         if (bad_opc) begin
            nxt_state.opcode = 5'd0;
            nxt_state.phase  = PH_IDLE;
            emit             = 1'b1;
         end else begin
            nxt_state.opcode = code_byte[4:0];
            if (code_byte inside {8'(OPC_LONG_ARG), 8'(OPC_SHORT_A),
                                  8'(OPC_SHORT_B), 8'(OPC_SHORT_C)}) begin
               adv             = find_arg(code_byte[4:0], 8'd0, 3'd0);
               nxt_state.phase = PH_ARGS;
               nxt_state.slot  = adv.slot;
               nxt_state.left  = adv.size;
            end else begin
               nxt_state.phase = PH_CODING;
            end
         end
      end else begin
         case (cur_state.phase)
            PH_CODING: begin
               // Take the coding byte, look for the first argument
               nxt_state.coding = code_byte;
               nxt_state.count  = cur_state.count + 5'd1;
               adv = find_arg(cur_state.opcode, code_byte, 3'd0);
               if (adv.found) begin
                  nxt_state.phase = PH_ARGS;
                  nxt_state.slot  = adv.slot;
                  nxt_state.left  = adv.size;
               end else begin
                  nxt_state.phase = PH_IDLE;
                  nxt_state.slot  = 2'd0;
                  nxt_state.left  = 3'd0;
                  emit            = 1'b1;
               end
            end
            PH_ARGS: begin
               // Shift the byte into the current argument
               nxt_state.accum[cur_state.slot] =
                  {cur_state.accum[cur_state.slot][23:0], code_byte};
               nxt_state.count = cur_state.count + 5'd1;
               left_dec = (cur_state.left != 3'd0) ? cur_state.left - 3'd1 : 3'd0;
               nxt_state.left = left_dec;
               if (left_dec == 3'd0) begin
                  adv = find_arg(cur_state.opcode, cur_state.coding,
                                 {1'b0, cur_state.slot} + 3'd1);
                  if (adv.found) begin
                     nxt_state.slot = adv.slot;
                     nxt_state.left = adv.size;
                  end else begin
                     nxt_state.phase = PH_IDLE;
                     nxt_state.slot  = 2'd0;
                     nxt_state.left  = 3'd0;
                     emit            = 1'b1;
                  end
               end
            end
            default: begin
               // Ignore stray bytes while idle
            end
         endcase
      end
   end

   // Build the result from the updated state
   always_comb begin
      result.valid_opcode = (nxt_state.opcode != 5'd0);
      result.opcode       = nxt_state.opcode;
      result.coding_byte  = nxt_state.coding;
      result.args         = nxt_state.accum;
      result.instr_length = nxt_state.count;
      if (nxt_state.opcode == 5'd0) begin
         result.coding_byte = 8'd0;
         result.args        = '0;
      end
   end

endmodule

// ----- src/bid_out_reg.sv -----
// ----------------------------------------------------------------------------
// Result register with skid stage
// Holds decoded results so the byte side keeps flowing while the
// result side stalls.
// ----------------------------------------------------------------------------
module bid_out_reg
   import bid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rsp_type push_data,
   output logic    push_space,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   logic    main_valid_ff;
   rsp_type main_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   logic    pop;

   assign pop        = main_valid_ff & out_ready;
   assign push_space = ~skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_data_ff;

   // Advance the main stage, park a result in the skid stage on a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_data_ff  <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push_valid;
            main_data_ff  <= push_data;
         end
      end else if (push_valid) begin
         if (!main_valid_ff) begin
            main_valid_ff <= 1'b1;
            main_data_ff  <= push_data;
         end else begin
            skid_valid_ff <= 1'b1;
            skid_data_ff  <= push_data;
         end
      end
   end

   // A result in the skid stage always has one ahead of it
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage full while main stage empty");

endmodule

// ----- src/bytecode_instruction_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Bytecode instruction decoder core
// Decodes a byte stream into instructions with up to four arguments.
//
//   channel | dir | tdata                         | tuser
//   req_    | in  | code byte                     | first byte flag
//   rsp_    | out | opcode, coding, args, length  | valid opcode flag
//
// One code byte is taken per cycle while req_tready is high; the state update is a single pass of
// logic between the decode state register and the result register.
// A result enters the result buffer as the instruction's last byte is taken.
// A two-entry result buffer lets the byte side run on while rsp_ stalls;
// req_tready drops only when both entries are full.
// Synchronous active-high reset returns the decoder to idle and empties
// the result buffer.
// ----------------------------------------------------------------------------
module bytecode_instruction_decoder_core
   import bid_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] code_byte
   input  logic         req_tuser,   // [0] first_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // [4:0] opcode, [12:5] coding_byte,
                                     // [44:13] arg_zero, [76:45] arg_one,
                                     // [108:77] arg_two, [140:109] arg_three,
                                     // [145:141] instr_length, rest zero
   output logic         rsp_tuser    // [0] valid_opcode
);

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      emit;
   rsp_type   step_rsp;
   rsp_type   out_rsp;

   assign accept = req_tvalid & req_tready;

   bid_step u_step (
      .cur_state  (state_ff),
      .code_byte  (req_tdata),
      .first_byte (req_tuser),
      .nxt_state  (state_in),
      .emit       (emit),
      .result     (step_rsp)
   );

   // Update decode state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, opcode: 5'd0, coding: 8'd0, slot: 2'd0,
                       left: 3'd0, accum: '0, count: 5'd0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   bid_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept & emit),
      .push_data  (step_rsp),
      .push_space (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (out_rsp),
      .out_ready  (rsp_tready)
   );

   // Pack the result transaction
   assign rsp_tuser = out_rsp.valid_opcode;
   assign rsp_tdata = {6'd0, out_rsp.instr_length,
                       out_rsp.args[3], out_rsp.args[2], out_rsp.args[1], out_rsp.args[0],
                       out_rsp.coding_byte, out_rsp.opcode};

   // An invalid opcode is a one-byte instruction with a cleared payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         out_rsp.instr_length == 5'd1 && out_rsp.opcode == 5'd0 &&
         out_rsp.args == '0)
      else $error("invalid opcode result malformed");

   // A decoded instruction always holds more than its opcode byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> out_rsp.instr_length >= 5'd2 &&
         out_rsp.opcode != 5'd0 && out_rsp.opcode <= OPC_MAX)
      else $error("valid result with bad opcode or length");

   // A start byte restarts the byte count
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> state_ff.count == 5'd1)
      else $error("byte count not restarted");

   // Argument phase always has bytes left to read
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_ARGS |-> state_ff.left != 3'd0)
      else $error("argument phase with nothing left");

endmodule

// ----- verif/instr_decode_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction decode checker
// Watches the byte and result channels of the bytecode instruction decoder,
// tracks the decode of every accepted byte with its own copy of the decoder
// state, and compares each accepted result, field by field, with the oldest
// decoded instruction still waiting.
// ----------------------------------------------------------------------------
module instr_decode_checker
   import bid_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] code_byte
   input  logic         req_tuser,   // [0] first_byte
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [151:0] rsp_tdata,   // [4:0] opcode, [12:5] coding_byte,
                                     // [44:13] arg_zero, [76:45] arg_one,
                                     // [108:77] arg_two, [140:109] arg_three,
                                     // [145:141] instr_length, rest zero
   input  logic         rsp_tuser,   // [0] valid_opcode
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic             valid;
      logic [4:0]       opcode;
      logic [7:0]       coding;
      logic [3:0][31:0] args;
      logic [4:0]       length;
   } decoded_instr_type;

   decoded_instr_type decoded_q[$];
   int                mismatch_total = 0;

   // Decoder state as tracked from the accepted bytes
   phase_type        dec_phase;
   logic [4:0]       cur_opc;
   logic [7:0]       cur_coding;
   logic [1:0]       cur_slot;
   logic [2:0]       bytes_to_go;
   logic [3:0][31:0] acc;
   logic [4:0]       n_bytes;

   assign fail_count = mismatch_total;

   // Byte count of one argument slot
   function automatic int arg_bytes(logic [4:0] opc, logic [7:0] coding, int slot);
      logic [1:0] code;
      code = 2'(coding >> (6 - 2 * slot));
      if (opc == OPC_BYTE_ARG) return (slot == 0) ? 1 : 0;
      if (opc == OPC_LONG_ARG) return (slot == 0) ? 4 : 0;
      if (opc == OPC_SHORT_A || opc == OPC_SHORT_B || opc == OPC_SHORT_C)
         return (slot == 0) ? 2 : 0;
      case (code)
         ARG_BYTE: return 1;
         ARG_HALF: return 2;
         ARG_WIDE: return (opc == OPC_HALF_A || opc == OPC_HALF_B ||
                           opc == OPC_HALF_C) ? 2 : 4;
         default:  return 0;
      endcase
   endfunction

   // First present slot at or after 'from', 4 when none is left
   function automatic int next_arg(int from);
      for (int i = from; i < NUM_ARGS; i++) begin
         if (arg_bytes(cur_opc, cur_coding, i) != 0) return i;
      end
      return NUM_ARGS;
   endfunction

   task automatic load_slot(input int s);
      cur_slot    = 2'(s);
      bytes_to_go = 3'(arg_bytes(cur_opc, cur_coding, s));
      dec_phase   = PH_ARGS;
   endtask

   // Queue the finished instruction and go back to idle
   task automatic post_result(input logic ok);
      decoded_instr_type d;
      d.valid  = ok;
      d.opcode = ok ? cur_opc : '0;
      d.coding = ok ? cur_coding : '0;
      d.args   = ok ? acc : '0;
      d.length = n_bytes;
      decoded_q.push_back(d);
      dec_phase   = PH_IDLE;
      bytes_to_go = '0;
      cur_slot    = '0;
   endtask

   // Advance the tracked decode by one accepted byte
   task automatic decode_byte(input logic [7:0] b, input logic first);
      int nxt;
      if (first) begin
         // a start flag always restarts, dropping any partial instruction
         acc         = '0;
         cur_coding  = '0;
         cur_slot    = '0;
         bytes_to_go = '0;
         n_bytes     = 5'd1;
         if (b == 8'd0 || b > 8'(OPC_MAX)) begin
            cur_opc = '0;
            post_result(1'b0);
         end else begin
            cur_opc = b[4:0];
            if (cur_opc == OPC_LONG_ARG || cur_opc == OPC_SHORT_A ||
                cur_opc == OPC_SHORT_B || cur_opc == OPC_SHORT_C) begin
               load_slot(next_arg(0));
            end else begin
               dec_phase = PH_CODING;
            end
         end
      end else if (dec_phase == PH_CODING) begin
         cur_coding = b;
         n_bytes    = n_bytes + 5'd1;
         nxt        = next_arg(0);
         if (nxt >= NUM_ARGS) post_result(1'b1);
         else load_slot(nxt);
      end else if (dec_phase == PH_ARGS) begin
         acc[cur_slot] = {acc[cur_slot][23:0], b};
         n_bytes       = n_bytes + 5'd1;
         if (bytes_to_go != 3'd0) bytes_to_go = bytes_to_go - 3'd1;
         if (bytes_to_go == 3'd0) begin
            nxt = next_arg(int'(cur_slot) + 1);
            if (nxt >= NUM_ARGS) post_result(1'b1);
            else load_slot(nxt);
         end
      end
      // stray bytes while idle are dropped
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_total++;
      end
   endtask

   // Compare results first, then track the byte taken at the same edge
   always @(posedge clock) begin : watch
      decoded_instr_type want;
      if (reset) begin
         decoded_q.delete();
         dec_phase   = PH_IDLE;
         cur_opc     = '0;
         cur_coding  = '0;
         cur_slot    = '0;
         bytes_to_go = '0;
         acc         = '0;
         n_bytes     = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $error("result transaction with no decoded instruction waiting");
               mismatch_total++;
            end else begin
               want = decoded_q.pop_front();
               check_field("valid_opcode", 32'(want.valid), 32'(rsp_tuser));
               check_field("opcode", 32'(want.opcode), 32'(rsp_tdata[4:0]));
               check_field("coding_byte", 32'(want.coding), 32'(rsp_tdata[12:5]));
               check_field("arg_zero", want.args[0], rsp_tdata[44:13]);
               check_field("arg_one", want.args[1], rsp_tdata[76:45]);
               check_field("arg_two", want.args[2], rsp_tdata[108:77]);
               check_field("arg_three", want.args[3], rsp_tdata[140:109]);
               check_field("instr_length", 32'(want.length), 32'(rsp_tdata[145:141]));
               check_field("tdata_pad", 32'd0, 32'(rsp_tdata[151:146]));
            end
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tuser);
      end
      pending <= decoded_q.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bytecode instruction decoder testbench
// Feeds a directed byte sequence and then mostly well-formed random
// instructions, mixed with invalid opcodes, cut-off instructions and stray
// bytes, under random gaps and result-side stalls; the checker decides.
// ----------------------------------------------------------------------------
module testbench;
   import bid_pkg::*;

   localparam logic [4:0] OPC_INVALID = 5'd0;
   localparam logic [4:0] OPC_GENERIC = 5'd3;   // any opcode with a coding byte
   localparam int         N_DIRECTED  = 23;
   localparam int         N_RANDOM    = 650;

   // {first_byte, code_byte}
   localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
      {1'b1, 3'b000, OPC_INVALID},
      {1'b1, 3'b000, OPC_MAX + 5'd1},
      {1'b1, 8'hff},
      {1'b0, 8'h5a},                                   // stray byte while idle
      {1'b1, 3'b000, OPC_GENERIC},
      {1'b0, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE},  // empty coding byte
      {1'b1, 3'b000, OPC_LONG_ARG},
      {1'b0, 8'hff}, {1'b0, 8'h00}, {1'b0, 8'h80}, {1'b0, 8'h01},
      {1'b1, 3'b000, OPC_BYTE_ARG},
      {1'b0, ARG_HALF, ARG_HALF, ARG_HALF, ARG_HALF},  // coding ignored
      {1'b0, 8'h80},
      {1'b1, 3'b000, OPC_HALF_A},
      {1'b0, ARG_WIDE, ARG_NONE, ARG_NONE, ARG_NONE},  // wide reads as 2 bytes
      {1'b0, 8'hab}, {1'b0, 8'hcd},
      {1'b1, 3'b000, OPC_SHORT_B},
      {1'b0, 8'h34},                                   // dropped by the restart
      {1'b1, 3'b000, OPC_SHORT_C},
      {1'b0, 8'hff}, {1'b0, 8'h00}
   };

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;    // [7:0] code_byte
   logic         req_tuser;    // [0] first_byte
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;    // [4:0] opcode, [12:5] coding_byte,
                               // [44:13] arg_zero, [76:45] arg_one,
                               // [108:77] arg_two, [140:109] arg_three,
                               // [145:141] instr_length, rest zero
   logic         rsp_tuser;    // [0] valid_opcode
   int           fail_count;
   int           pending;
   int           item_total = 0;
   int           sent_total = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bytecode_instruction_decoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   instr_decode_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Total bytes of a well-formed instruction, opcode included
   function automatic int instr_length_of(logic [7:0] opc, logic [7:0] coding);
      int         total;
      logic [1:0] code;
      if (opc == OPC_LONG_ARG) return 5;
      if (opc == OPC_SHORT_A || opc == OPC_SHORT_B || opc == OPC_SHORT_C ||
          opc == OPC_BYTE_ARG) return 3;
      total = 2;
      for (int s = 0; s < NUM_ARGS; s++) begin
         code = 2'(coding >> (6 - 2 * s));
         case (code)
            ARG_BYTE: total += 1;
            ARG_HALF: total += 2;
            ARG_WIDE: total += (opc == OPC_HALF_A || opc == OPC_HALF_B ||
                                opc == OPC_HALF_C) ? 2 : 4;
            default:  ;
         endcase
      end
      return total;
   endfunction

   // Offer one byte after a random gap, hold it until the transaction
   task automatic send_byte(input logic [7:0] b, input logic first);
      int gap;
      gap = ((sent_total / 40) % 5 == 3) ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      sent_total++;
   endtask

   // Send an instruction with random argument bytes, cut after 'cut' bytes
   task automatic send_instr(input logic [7:0] opc, input logic [7:0] coding,
                             input int cut);
      int n;
      bit has_coding;
      has_coding = !(opc == OPC_LONG_ARG || opc == OPC_SHORT_A ||
                     opc == OPC_SHORT_B || opc == OPC_SHORT_C);
      n = instr_length_of(opc, coding);
      if (cut < n) n = cut;
      send_byte(opc, 1'b1);
      for (int k = 1; k < n; k++) begin
         if (k == 1 && has_coding) send_byte(coding, 1'b0);
         else send_byte(8'($urandom), 1'b0);
      end
      item_total += n;
   endtask

   // Stop offering and hold until every decoded instruction has come out
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Result side: random stalls, one long hold-off, stretches with none
   initial begin : receiver
      int gap;
      int taken;
      bit long_hold_done;
      taken          = 0;
      long_hold_done = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && taken == 15) begin
            gap            = 400;
            long_hold_done = 1;
         end else if ((taken / 12) % 4 == 2) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 19);
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // Byte side: reset, directed sequence, random instructions, verdict
   initial begin : stimulus
      int         pick;
      int         r;
      bit         paused_once;
      logic [7:0] opc;
      logic [7:0] coding;
      paused_once = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
         item_total++;
      end
      wait_for_results();

      while (item_total < N_DIRECTED + N_RANDOM) begin
         if (!paused_once && item_total >= 300) begin
            wait_for_results();
            paused_once = 1;
         end
         pick = $urandom_range(0, 99);
         opc  = 8'($urandom_range(1, OPC_MAX));
         r    = $urandom_range(0, 9);
         coding = (r == 0) ? 8'h00 : (r == 1) ? 8'haa : (r == 2) ? 8'hff : 8'($urandom);
         if (pick < 6) begin
            // invalid opcode
            opc = ($urandom_range(0, 3) == 0) ? 8'(OPC_INVALID) : 8'($urandom_range(17, 255));
            send_byte(opc, 1'b1);
            item_total++;
         end else if (pick < 12) begin
            // instruction cut short, the next start flag drops it
            send_instr(opc, coding, $urandom_range(1, instr_length_of(opc, coding) - 1));
         end else if (pick < 16) begin
            // bytes without a start flag
            repeat ($urandom_range(1, 3)) begin
               send_byte(8'($urandom), 1'b0);
               item_total++;
            end
         end else begin
            send_instr(opc, coding, 32);
         end
      end
      wait_for_results();
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Hard limit on run length
   initial begin : watchdog
      #400000;
      $display("testbench: errors");
      $finish;
   end

endmodule
